/* hdl/gaussian_row_smoother_defines.svh */
// assertion macros shared by the gaussian row smoother modules
`ifndef GAUSSIAN_ROW_SMOOTHER_DEFINES_SVH
`define GAUSSIAN_ROW_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define GRS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gaussian row smoother: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gaussian row smoother: assertion failed");

`else

`define GRS_ASSERT_IMPLIES(label, ante, cons)

`define GRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/grs_pkg.sv */
// shared constants, register codes and config type of the gaussian row smoother
package grs_pkg;

	// default sizes
	localparam int MAX_RADIUS_DEF   = 3;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int QUEUE_DEPTH_DEF  = 2;

	// register field widths
	localparam int RADIUS_W   = 2;
	localparam int TAP_W      = 16;
	localparam int NUM_TAPS   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP3   = 3'd4;

	// reset values
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
	localparam logic [TAP_W-1:0]    TAP0_RESET   = 16'hFFFF;
	localparam logic [TAP_W-1:0]    TAPN_RESET   = 16'h0000;

	// live configuration
	typedef struct packed {
		logic [RADIUS_W-1:0]              radius;
		logic [NUM_TAPS-1:0][TAP_W-1:0]   taps;
	} cfg_t;

endpackage

/* hdl/gaussian_row_smoother.sv */
// top level: config registers, front end, job queue and divider back end
// the serial divider takes no new job until its result has gone to the output register;
//   a row-end item yields up to R+1 results, one divider pass each
// path: multiply-accumulate in the front end, the job queue, then the serial divider
//   and its output register
// reset: arst_n low clears all control state and loads the register reset values
module gaussian_row_smoother #(
	parameter int MAX_RADIUS   = grs_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_WIDTH = grs_pkg::SAMPLE_WIDTH_DEF,
	parameter int QUEUE_DEPTH  = grs_pkg::QUEUE_DEPTH_DEF,
	localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [grs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [TDATA_W-1:0]              s_axis_tdata,   // sample
	input  logic                            s_axis_tlast,   // row_end
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [TDATA_W-1:0]              m_axis_tdata,   // smoothed
	output logic                            m_axis_tlast    // last_of_row
);

	localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int ACC_W     = SAMPLE_WIDTH + 16 + $clog2(WIN_DEPTH);
	localparam int DEN_W     = 16 + $clog2(WIN_DEPTH);
	localparam int JOB_W     = ACC_W + DEN_W + 1;

	grs_pkg::cfg_t cfg_q;

	logic                    job_valid;
	logic                    job_ready;
	logic [ACC_W-1:0]        job_num;
	logic [DEN_W-1:0]        job_den;
	logic                    job_last;
	logic                    div_valid;
	logic                    div_ready;
	logic [JOB_W-1:0]        div_job;
	logic [SAMPLE_WIDTH-1:0] smoothed;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius  <= grs_pkg::RADIUS_RESET;
			cfg_q.taps[0] <= grs_pkg::TAP0_RESET;
			cfg_q.taps[1] <= grs_pkg::TAPN_RESET;
			cfg_q.taps[2] <= grs_pkg::TAPN_RESET;
			cfg_q.taps[3] <= grs_pkg::TAPN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				grs_pkg::CFG_RADIUS: cfg_q.radius  <= cfg_data[grs_pkg::RADIUS_W-1:0];
				grs_pkg::CFG_TAP0:   cfg_q.taps[0] <= cfg_data;
				grs_pkg::CFG_TAP1:   cfg_q.taps[1] <= cfg_data;
				grs_pkg::CFG_TAP2:   cfg_q.taps[2] <= cfg_data;
				grs_pkg::CFG_TAP3:   cfg_q.taps[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// window and multiply-accumulate
	grs_front #(
		.MAX_RADIUS   (MAX_RADIUS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_W        (ACC_W),
		.DEN_W        (DEN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.in_end    (s_axis_tlast),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_num   (job_num),
		.job_den   (job_den),
		.job_last  (job_last)
	);

	// decoupling queue
	grs_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_ready (job_ready),
		.wr_data  ({job_last, job_den, job_num}),
		.rd_valid (div_valid),
		.rd_ready (div_ready),
		.rd_data  (div_job)
	);

	// normalizing divider
	grs_divider #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_W        (ACC_W),
		.DEN_W        (DEN_W)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_num    (div_job[ACC_W-1:0]),
		.in_den    (div_job[ACC_W+DEN_W-1:ACC_W]),
		.in_last   (div_job[JOB_W-1]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (smoothed),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = TDATA_W'(smoothed);

endmodule

/* hdl/grs_front.sv */
// front end: sample window, center selection and serial multiply-accumulate per result
`include "gaussian_row_smoother_defines.svh"

module grs_front #(
	parameter int MAX_RADIUS   = grs_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_WIDTH = grs_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_W        = SAMPLE_WIDTH + 16 + $clog2(2 * MAX_RADIUS + 1),
	parameter int DEN_W        = 16 + $clog2(2 * MAX_RADIUS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  grs_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                    in_end,
	output logic                    job_valid,
	input  logic                    job_ready,
	output logic [ACC_W-1:0]        job_num,
	output logic [DEN_W-1:0]        job_den,
	output logic                    job_last
);

	localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int IDX_W     = $clog2(WIN_DEPTH);
	localparam int R_W       = $clog2(MAX_RADIUS + 1);
	localparam int PROD_W    = SAMPLE_WIDTH + 17;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_PUSH  = 2'd3;

	logic [1:0]                     state_q;
	logic signed [SAMPLE_WIDTH-1:0] win_q [WIN_DEPTH];
	logic [WIN_DEPTH-1:0]           vld_q;
	logic [R_W-1:0]                 r_q;
	logic [R_W-1:0]                 c_q;
	logic [IDX_W-1:0]               k_q;
	logic                           end_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic [DEN_W-1:0]               den_q;
	logic signed [PROD_W-1:0]       prod_s1;
	logic                           mul_vld_s1;

	logic [R_W-1:0]       eff_r;
	logic [WIN_DEPTH-1:0] vld_next;
	logic [R_W-1:0]       top_c;
	logic                 has_job;
	logic                 accept;
	logic                 push_done;
	logic                 next_job;
	logic                 start_acc;
	logic [IDX_W-1:0]     two_r;
	logic [IDX_W:0]       idx_ext;
	logic [IDX_W:0]       idx_diff;
	logic [IDX_W-1:0]     idx;
	logic                 in_row;
	logic [IDX_W-1:0]     tap_dist;
	logic [1:0]           tap_sel;
	logic [15:0]          tap_w;
	logic                 use_tap;
	logic signed [PROD_W-1:0] prod_w;

	// effective radius, limited to the window size
	always_comb begin
		if (32'(cfg.radius) > MAX_RADIUS) begin
			eff_r = R_W'(MAX_RADIUS);
		end else begin
			eff_r = R_W'(cfg.radius);
		end
	end

	// valid bits after the incoming item and the oldest center still in the row
	always_comb begin
		vld_next = {vld_q[WIN_DEPTH-2:0], 1'b1};
		top_c    = '0;
		for (int t = 0; t <= MAX_RADIUS; t++) begin
			if (R_W'(t) <= eff_r && vld_next[t]) begin
				top_c = R_W'(t);
			end
		end
		has_job = in_end || vld_next[IDX_W'(eff_r)];
	end

	// handshake events
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign job_valid = (state_q == ST_PUSH);
	assign push_done = job_valid && job_ready;
	assign next_job  = push_done && end_q && (c_q != '0);
	assign start_acc = (accept && has_job) || next_job;

	// tap position walk across the window around the center
	always_comb begin
		two_r    = IDX_W'({r_q, 1'b0});
		idx_ext  = (IDX_W + 1)'(c_q) + (IDX_W + 1)'(k_q);
		in_row   = idx_ext >= (IDX_W + 1)'(r_q);
		idx_diff = idx_ext - (IDX_W + 1)'(r_q);
		idx      = idx_diff[IDX_W-1:0];
		if (k_q >= IDX_W'(r_q)) begin
			tap_dist = k_q - IDX_W'(r_q);
		end else begin
			tap_dist = IDX_W'(r_q) - k_q;
		end
		tap_sel = tap_dist[1:0];
		tap_w   = cfg.taps[tap_sel];
		use_tap = in_row && vld_q[idx];
	end

	// one weight times one sample per cycle
	assign prod_w = win_q[idx] * $signed({1'b0, tap_w});

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			end_q      <= 1'b0;
			mul_vld_s1 <= 1'b0;
		end else begin
			mul_vld_s1 <= (state_q == ST_MAC) && use_tap;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						vld_q <= vld_next;
						r_q   <= eff_r;
						end_q <= in_end;
						c_q   <= in_end ? top_c : eff_r;
						k_q   <= '0;
						if (has_job) begin
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == two_r) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_done) begin
						if (next_job) begin
							c_q     <= c_q - 1'b1;
							k_q     <= '0;
							state_q <= ST_MAC;
						end else begin
							if (end_q) begin
								vld_q <= '0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window shift, product and sums
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = WIN_DEPTH - 1; k > 0; k--) begin
				win_q[k] <= win_q[k-1];
			end
			win_q[0] <= in_sample;
		end
		prod_s1 <= prod_w;
		if (start_acc) begin
			acc_q <= '0;
			den_q <= '0;
		end else begin
			if (mul_vld_s1) begin
				acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
			end
			if (state_q == ST_MAC && use_tap) begin
				den_q <= den_q + DEN_W'(tap_w);
			end
		end
	end

	// job to the queue
	assign job_num  = acc_q;
	assign job_den  = den_q;
	assign job_last = end_q && (c_q == '0);

	`GRS_ASSERT_IMPLIES(a_k_in_window, state_q == ST_MAC, k_q <= two_r)
	`GRS_ASSERT_NEXT(a_row_cleared, push_done && end_q && c_q == '0, vld_q == '0)

endmodule

/* hdl/grs_queue.sv */
// short job queue between front end and divider
`include "gaussian_row_smoother_defines.svh"

module grs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = grs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`GRS_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

/* hdl/grs_divider.sv */
// back end: serial restoring divider, rounding, clamping and output register
`include "gaussian_row_smoother_defines.svh"

module grs_divider #(
	parameter int SAMPLE_WIDTH = grs_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_W        = SAMPLE_WIDTH + 19,
	parameter int DEN_W        = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACC_W-1:0]        in_num,
	input  logic [DEN_W-1:0]        in_den,
	input  logic                    in_last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] out_data,
	output logic                    out_last
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CNT_W = $clog2(SW + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [SW:0] POS_LIM = {2'b00, {(SW - 1){1'b1}}};
	localparam logic [SW:0] NEG_LIM = {2'b01, {(SW - 1){1'b0}}};

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [SW-1:0]    quo_q;
	logic             neg_q;
	logic             last_q;
	logic [SW-1:0]    res_q;
	logic             out_valid_q;
	logic [SW-1:0]    out_data_q;
	logic             out_last_q;

	logic             accept;
	logic             load_out;
	logic [ACC_W-1:0] mag;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic             round_up;
	logic [SW:0]      qr;
	logic [SW:0]      qsat;
	logic [SW-1:0]    res_w;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// magnitude of the weighted sum
	assign mag = in_num[ACC_W-1] ? (~in_num + 1'b1) : in_num;

	// one quotient bit per step
	always_comb begin
		rem_sh = {rem_q, quo_q[SW-1]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	// round half away from zero, clamp, apply sign
	always_comb begin
		round_up = {rem_q, 1'b0} >= {1'b0, den_q};
		qr       = {1'b0, quo_q} + (SW + 1)'(round_up);
		if (neg_q) begin
			qsat  = (qr > NEG_LIM) ? NEG_LIM : qr;
			res_w = ~qsat[SW-1:0] + 1'b1;
		end else begin
			qsat  = (qr > POS_LIM) ? POS_LIM : qr;
			res_w = qsat[SW-1:0];
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= CNT_W'(SW);
						state_q <= (in_den == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= mag[ACC_W-1:SW];
			quo_q  <= mag[SW-1:0];
			den_q  <= in_den;
			neg_q  <= in_num[ACC_W-1];
			last_q <= in_last;
			res_q  <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end else if (state_q == ST_ROUND) begin
			res_q <= res_w;
		end
		if (load_out) begin
			out_data_q <= res_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	`GRS_ASSERT_IMPLIES(a_rem_below_den, state_q == ST_DIV || state_q == ST_ROUND, rem_q < den_q)

endmodule
